[rtl/core/bpto_pkg.sv]
package bpto_pkg;

	localparam int BPTO_NODE_COUNT = 1024;
	localparam int BPTO_KEY_BITS   = 32;
	localparam int KEY_W           = 32;
	localparam int WC_W            = 6;
	localparam int CMD_W           = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_QUERY  = 2'd1,
		CMD_CLEAR  = 2'd2
	} bpto_cmd_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_WALK = 1'b1
	} bpto_state_t;

endpackage

[rtl/core/binary_prefix_trie_overlap.sv]
// Binary prefix trie with insert, overlap query and clear transactions. A transaction is taken
// when start is high and busy is low. Its result appears on match and status for exactly one
// cycle, marked by done, and the receiver cannot stall it. Clear, rejected inserts, full-wildcard
// transactions, unused commands and queries that meet a marked root keep busy low, and their
// result appears in the cycle right after they are taken. An insert that walks holds busy while
// it steps down one node per key bit walked (KEY_BITS minus wildcard_bits) and then does a final
// write that marks the last node. A query that walks holds busy while it steps down at most one
// node per key bit walked and stops early at a missing or marked node. A walking transaction
// gives its result in the first cycle in which busy is low again. Each step uses the node
// memory, which gives one synchronous read or one write per cycle. The root lives in registers,
// so reset and clear are immediate and no clearing pass is needed.
module binary_prefix_trie_overlap #(
	parameter int NODE_COUNT = bpto_pkg::BPTO_NODE_COUNT,
	parameter int KEY_BITS   = bpto_pkg::BPTO_KEY_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [bpto_pkg::CMD_W-1:0] command,
	input  logic [bpto_pkg::KEY_W-1:0] key,
	input  logic [bpto_pkg::WC_W-1:0]  wildcard_bits,
	output logic                       done,
	output logic                       match,
	output logic                       status
);
	import bpto_pkg::*;

	localparam int IDX_W = $clog2(NODE_COUNT);
	localparam int CNT_W = $clog2(NODE_COUNT + 1);
	localparam int LEN_W = $clog2(KEY_BITS + 1);
	localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
	localparam int KW    = (KEY_BITS > KEY_W) ? KEY_BITS : KEY_W;

	typedef struct packed {
		logic [IDX_W-1:0] left;
		logic [IDX_W-1:0] right;
		logic             mark;
	} entry_t;

	entry_t mem [NODE_COUNT];

	bpto_state_t state_q, state_d;
	logic [CNT_W-1:0] used_q;
	entry_t root_q;
	logic done_q, match_q, status_q;

	logic is_ins_q;
	logic [KEY_BITS-1:0] key_q;
	logic [LEN_W-1:0] rem_q;
	logic [IDX_W-1:0] cur_q;
	logic fresh_q;
	entry_t rdata_q;

	logic accept;
	logic [KW-1:0] key_wide;
	logic [KEY_BITS-1:0] key_in;
	logic [6:0] len_full;
	logic [LEN_W-1:0] len_in;
	logic [CMP_W-1:0] free_cnt;
	logic full_in;

	logic go_walk, imm_done, imm_match, imm_status, do_clear, root_mark;
	logic finish, fin_match, fin_status;
	logic advance, alloc;
	logic rd_en, wr_req;
	logic [IDX_W-1:0] nxt_idx, slot;
	entry_t ce, wr_data;

	assign accept   = start && (state_q == ST_IDLE);
	assign key_wide = KW'(key);
	assign key_in   = key_wide[KEY_BITS-1:0];
	assign len_full = ({1'b0, wildcard_bits} >= 7'(KEY_BITS)) ? 7'd0
		: 7'(KEY_BITS) - {1'b0, wildcard_bits};
	assign len_in   = LEN_W'(len_full);
	assign free_cnt = CMP_W'(NODE_COUNT) - CMP_W'(used_q);
	assign full_in  = free_cnt < CMP_W'(len_in);

	assign ce   = (cur_q == '0) ? root_q : (fresh_q ? entry_t'('0) : rdata_q);
	assign slot = key_q[KEY_BITS-1] ? ce.right : ce.left;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && go_walk)
					state_d = ST_WALK;
			end
			ST_WALK: begin
				if (finish)
					state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		go_walk    = 1'b0;
		imm_done   = 1'b0;
		imm_match  = 1'b0;
		imm_status = 1'b0;
		do_clear   = 1'b0;
		root_mark  = 1'b0;
		finish     = 1'b0;
		fin_match  = 1'b0;
		fin_status = 1'b0;
		advance    = 1'b0;
		alloc      = 1'b0;
		rd_en      = 1'b0;
		wr_req     = 1'b0;
		nxt_idx    = slot;
		wr_data    = ce;
		if (accept) begin
			imm_done = 1'b1;
			unique case (command)
				CMD_INSERT: begin
					if (full_in) begin
						imm_status = 1'b1;
					end else if (len_in == '0) begin
						root_mark = 1'b1;
					end else begin
						go_walk  = 1'b1;
						imm_done = 1'b0;
					end
				end
				CMD_QUERY: begin
					if (root_q.mark) begin
						imm_match = 1'b1;
					end else if (len_in == '0) begin
						imm_match = (root_q.left != '0) || (root_q.right != '0);
					end else begin
						go_walk  = 1'b1;
						imm_done = 1'b0;
					end
				end
				CMD_CLEAR: begin
					do_clear = 1'b1;
				end
				default: begin
				end
			endcase
		end
		if (state_q == ST_WALK) begin
			if (is_ins_q) begin
				if (rem_q == '0) begin
					wr_req       = 1'b1;
					wr_data.mark = 1'b1;
					finish       = 1'b1;
				end else if (slot == '0) begin
					alloc   = 1'b1;
					advance = 1'b1;
					wr_req  = 1'b1;
					nxt_idx = used_q[IDX_W-1:0];
					if (key_q[KEY_BITS-1])
						wr_data.right = used_q[IDX_W-1:0];
					else
						wr_data.left = used_q[IDX_W-1:0];
				end else begin
					advance = 1'b1;
					rd_en   = 1'b1;
				end
			end else begin
				if ((cur_q != '0) && ce.mark) begin
					finish    = 1'b1;
					fin_match = 1'b1;
				end else if (slot == '0) begin
					finish = 1'b1;
				end else if (rem_q == LEN_W'(1)) begin
					finish    = 1'b1;
					fin_match = 1'b1;
				end else begin
					advance = 1'b1;
					rd_en   = 1'b1;
				end
			end
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign match  = match_q;
	assign status = status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			used_q   <= CNT_W'(1);
			root_q   <= '0;
			done_q   <= 1'b0;
			match_q  <= 1'b0;
			status_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			done_q   <= imm_done || finish;
			match_q  <= (imm_match && imm_done) || (fin_match && finish);
			status_q <= (imm_status && imm_done) || (fin_status && finish);
			if (do_clear) begin
				root_q <= '0;
				used_q <= CNT_W'(1);
			end else begin
				if (root_mark)
					root_q.mark <= 1'b1;
				if (wr_req && (cur_q == '0))
					root_q <= wr_data;
				if (alloc)
					used_q <= used_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			is_ins_q <= (command == CMD_INSERT);
			key_q    <= key_in;
			rem_q    <= len_in;
			cur_q    <= '0;
			fresh_q  <= 1'b0;
		end else if (advance) begin
			key_q   <= key_q << 1;
			rem_q   <= rem_q - LEN_W'(1);
			cur_q   <= nxt_idx;
			fresh_q <= alloc;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_req && (cur_q != '0))
			mem[cur_q] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rdata_q <= mem[slot];
	end

endmodule

[tb/tb_top.sv]
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bpto_pkg::*;

	localparam int IDX_W = $clog2(BPTO_NODE_COUNT);
	localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;
	localparam int RANDOM_ITEMS = 650;
	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 40;
	localparam int REPORT_MAX = 10;

	typedef enum int {
		PHASE_FILL,
		PHASE_MIXED,
		PHASE_NOISE
	} phase_kind_t;

	typedef struct packed {
		logic match;
		logic status;
	} result_t;

	typedef struct packed {
		logic [KEY_W-1:0] k;
		logic [WC_W-1:0]  wc;
	} prefix_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [KEY_W-1:0] k;
		logic [WC_W-1:0]  wc;
		bit               typed;
		logic             m;
		logic             s;
	} dir_row_t;

	localparam dir_row_t DIRECTED [24] = '{
		'{CMD_QUERY,  32'h0000_0000, 6'd0,  1'b1, 1'b0, 1'b0},
		'{CMD_QUERY,  32'hFFFF_FFFF, 6'd32, 1'b1, 1'b0, 1'b0},
		'{CMD_QUERY,  32'h1234_5678, 6'd63, 1'b1, 1'b0, 1'b0},
		'{CMD_INSERT, 32'hFFFF_FFFF, 6'd0,  1'b1, 1'b0, 1'b0},
		'{CMD_QUERY,  32'hFFFF_FFFF, 6'd0,  1'b1, 1'b1, 1'b0},
		'{CMD_QUERY,  32'h0000_0000, 6'd0,  1'b1, 1'b0, 1'b0},
		'{CMD_QUERY,  32'h7FFF_FFFF, 6'd0,  1'b1, 1'b0, 1'b0},
		'{CMD_QUERY,  32'h0000_0000, 6'd32, 1'b1, 1'b1, 1'b0},
		'{CMD_QUERY,  32'hF000_0000, 6'd28, 1'b0, 1'b0, 1'b0},
		'{CMD_NONE,   32'hFFFF_FFFF, 6'd63, 1'b1, 1'b0, 1'b0},
		'{CMD_INSERT, 32'h0000_0000, 6'd0,  1'b1, 1'b0, 1'b0},
		'{CMD_INSERT, 32'hA5A5_A5A5, 6'd33, 1'b1, 1'b0, 1'b0},
		'{CMD_QUERY,  32'h5A5A_5A5A, 6'd0,  1'b1, 1'b1, 1'b0},
		'{CMD_CLEAR,  32'hFFFF_FFFF, 6'd63, 1'b1, 1'b0, 1'b0},
		'{CMD_QUERY,  32'h0000_0000, 6'd32, 1'b1, 1'b0, 1'b0},
		'{CMD_INSERT, 32'h8000_0000, 6'd31, 1'b1, 1'b0, 1'b0},
		'{CMD_QUERY,  32'hC000_0000, 6'd0,  1'b0, 1'b0, 1'b0},
		'{CMD_QUERY,  32'h4000_0000, 6'd0,  1'b0, 1'b0, 1'b0},
		'{CMD_INSERT, 32'h3C3C_3C3C, 6'd16, 1'b0, 1'b0, 1'b0},
		'{CMD_QUERY,  32'h3C3C_0000, 6'd17, 1'b0, 1'b0, 1'b0},
		'{CMD_QUERY,  32'h3C3D_0000, 6'd16, 1'b0, 1'b0, 1'b0},
		'{CMD_INSERT, 32'h0000_0001, 6'd63, 1'b0, 1'b0, 1'b0},
		'{CMD_QUERY,  32'hFFFF_FFFF, 6'd0,  1'b0, 1'b0, 1'b0},
		'{CMD_CLEAR,  32'h0000_0000, 6'd0,  1'b1, 1'b0, 1'b0}
	};

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic [CMD_W-1:0] command;
	logic [KEY_W-1:0] key;
	logic [WC_W-1:0]  wildcard_bits;
	logic             done;
	logic             match;
	logic             status;

	logic [IDX_W-1:0] trie_left  [BPTO_NODE_COUNT];
	logic [IDX_W-1:0] trie_right [BPTO_NODE_COUNT];
	logic             trie_mark  [BPTO_NODE_COUNT];
	logic [IDX_W:0]   trie_used;

	result_t pending_results[$];
	prefix_t stored_prefixes[$];
	int      mismatches;
	int      quiet_cycles;
	int      random_sent;
	bit      idling_on;

	binary_prefix_trie_overlap dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.command       (command),
		.key           (key),
		.wildcard_bits (wildcard_bits),
		.done          (done),
		.match         (match),
		.status        (status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void trie_reset();
		foreach (trie_left[i]) begin
			trie_left[i]  = '0;
			trie_right[i] = '0;
			trie_mark[i]  = 1'b0;
		end
		trie_used = 1;
	endfunction

	function automatic void trie_apply(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] k,
			input logic [WC_W-1:0] wc, output logic m, output logic s);
		int               len;
		logic [IDX_W-1:0] cur;
		logic [IDX_W-1:0] nxt;
		logic             b;
		bit               stop;
		m = 1'b0;
		s = 1'b0;
		len = (wc > BPTO_KEY_BITS) ? 0 : BPTO_KEY_BITS - int'(wc);
		case (cmd)
			CMD_INSERT: begin
				if (BPTO_NODE_COUNT - int'(trie_used) < len) begin
					s = 1'b1;
				end else begin
					cur = '0;
					for (int i = 0; i < len; i++) begin
						b = k[BPTO_KEY_BITS-1-i];
						nxt = b ? trie_right[cur] : trie_left[cur];
						if (nxt == '0) begin
							nxt = trie_used[IDX_W-1:0];
							trie_left[nxt]  = '0;
							trie_right[nxt] = '0;
							trie_mark[nxt]  = 1'b0;
							trie_used = trie_used + 1'b1;
							if (b) trie_right[cur] = nxt;
							else trie_left[cur] = nxt;
						end
						cur = nxt;
					end
					trie_mark[cur] = 1'b1;
				end
			end
			CMD_QUERY: begin
				if (trie_mark[0]) begin
					m = 1'b1;
				end else if (len == 0) begin
					m = (trie_left[0] != '0) || (trie_right[0] != '0);
				end else begin
					m = 1'b1;
					stop = 1'b0;
					cur = '0;
					for (int i = 0; i < len && !stop; i++) begin
						nxt = k[BPTO_KEY_BITS-1-i] ? trie_right[cur] : trie_left[cur];
						if (nxt == '0) begin
							m = 1'b0;
							stop = 1'b1;
						end else begin
							cur = nxt;
							if (trie_mark[cur]) stop = 1'b1;
						end
					end
				end
			end
			CMD_CLEAR: trie_reset();
			default: ;
		endcase
	endfunction

	task automatic send_transaction(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] k,
			input logic [WC_W-1:0] wc, input bit typed, input logic tm, input logic ts);
		logic    pm;
		logic    ps;
		result_t r;
		if (idling_on) begin
			while ($urandom_range(0, 99) < 36) begin
				start <= 1'b0;
				@(posedge clk);
			end
		end
		start         <= 1'b1;
		command       <= cmd;
		key           <= k;
		wildcard_bits <= wc;
		do @(posedge clk); while (busy);
		trie_apply(cmd, k, wc, pm, ps);
		if (typed) begin
			r.match  = tm;
			r.status = ts;
		end else begin
			r.match  = pm;
			r.status = ps;
		end
		pending_results = {pending_results, r};
		if (cmd == CMD_CLEAR) stored_prefixes.delete();
	endtask

	task automatic pick_overlap_query(output logic [KEY_W-1:0] k, output logic [WC_W-1:0] wc);
		prefix_t p;
		wc = 6'($urandom_range(0, 32));
		if (stored_prefixes.size() == 0) begin
			k = $urandom;
		end else begin
			p = stored_prefixes[$urandom_range(0, stored_prefixes.size() - 1)];
			k = p.k;
			if ($urandom_range(0, 99) < 30) k[$urandom_range(0, KEY_W - 1)] ^= 1'b1;
		end
	endtask

	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				if (mismatches < REPORT_MAX)
					$display("Unexpected result: match %0b status %0b", match, status);
				mismatches++;
			end else begin
				exp_r = pending_results.pop_front();
				if (match !== exp_r.match) begin
					if (mismatches < REPORT_MAX)
						$display("Mismatch on match: expected %0b, got %0b", exp_r.match, match);
					mismatches++;
				end
				if (status !== exp_r.status) begin
					if (mismatches < REPORT_MAX)
						$display("Mismatch on status: expected %0b, got %0b", exp_r.status,
							status);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && ((start && !busy) || done)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		phase_kind_t      phase;
		int               phase_len;
		int               r;
		bit               first_phase;
		logic [CMD_W-1:0] cmd;
		logic [KEY_W-1:0] k;
		logic [WC_W-1:0]  wc;
		prefix_t          p;
		arst_n        = 1'b0;
		start         = 1'b0;
		command       = CMD_INSERT;
		key           = '0;
		wildcard_bits = '0;
		mismatches    = 0;
		quiet_cycles  = 0;
		random_sent   = 0;
		idling_on     = 1'b1;
		trie_reset();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i])
			send_transaction(DIRECTED[i].cmd, DIRECTED[i].k, DIRECTED[i].wc, DIRECTED[i].typed,
				DIRECTED[i].m, DIRECTED[i].s);

		first_phase = 1'b1;
		while (random_sent < RANDOM_ITEMS) begin
			phase = first_phase ? PHASE_FILL : phase_kind_t'($urandom_range(0, 2));
			if (first_phase || $urandom_range(0, 3) != 0) begin
				send_transaction(CMD_CLEAR, $urandom, 6'($urandom_range(0, 63)), 1'b0, 1'b0,
					1'b0);
				random_sent++;
			end
			first_phase = 1'b0;
			phase_len = (phase == PHASE_FILL) ? 70 : $urandom_range(20, 70);
			for (int n = 0; n < phase_len && random_sent < RANDOM_ITEMS; n++) begin
				idling_on = !(random_sent >= 200 && random_sent < 350);
				r = $urandom_range(0, 99);
				cmd = CMD_QUERY;
				k = $urandom;
				wc = 6'($urandom_range(0, 32));
				case (phase)
					PHASE_FILL: begin
						if (r < 75) begin
							cmd = CMD_INSERT;
							wc = 6'($urandom_range(0, 3));
						end else if (r < 85 && stored_prefixes.size() != 0) begin
							cmd = CMD_INSERT;
							p = stored_prefixes[$urandom_range(0, stored_prefixes.size() - 1)];
							k = p.k;
							wc = p.wc;
						end else if (r < 88) begin
							cmd = CMD_INSERT;
							wc = 6'($urandom_range(32, 63));
						end else begin
							pick_overlap_query(k, wc);
						end
					end
					PHASE_MIXED: begin
						if (r < 40) cmd = CMD_INSERT;
						else if (r < 85) pick_overlap_query(k, wc);
						else if (r >= 93) begin
							cmd = 2'($urandom_range(0, 3));
							wc = 6'($urandom_range(0, 63));
						end
					end
					default: begin
						if (r < 50) begin
							cmd = 2'($urandom_range(0, 3));
							wc = 6'($urandom_range(0, 63));
						end else begin
							pick_overlap_query(k, wc);
						end
					end
				endcase
				if (cmd == CMD_INSERT) begin
					p.k = k;
					p.wc = wc;
					stored_prefixes = {stored_prefixes, p};
				end
				send_transaction(cmd, k, wc, 1'b0, 1'b0, 1'b0);
				random_sent++;
			end
		end
		start <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

[filelist.f]
rtl/core/bpto_pkg.sv
rtl/core/binary_prefix_trie_overlap.sv
tb/tb_top.sv
